[src/fbth_pkg.sv]
// Shared types and constants for the first-fit boundary-tag heap.
// Used by the pool RAM and by the top level; depends on nothing else.
`default_nettype none
package fbth_pkg;

    // Default values of the top-level parameters.
    localparam int unsigned DEF_POOL_BYTES     = 4096;
    localparam int unsigned DEF_ALIGN_UNIT     = 4;
    localparam int unsigned DEF_MIN_DATA_BYTES = 8;

    // Block layout: header, data area, footer.
    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned FTR_BYTES = 2;
    localparam int unsigned OVH_BYTES = HDR_BYTES + FTR_BYTES;

    // Byte offsets of the header fields inside a block.
    localparam int unsigned OFF_SIZE  = 2;
    localparam int unsigned OFF_FLAGS = 4;
    localparam int unsigned OFF_OWNER = 6;
    localparam int unsigned OFF_PAD   = 8;

    // Width of the offset and size arithmetic; holds a block offset plus a full 16-bit size
    // plus padding without wrapping.
    localparam int unsigned XW = 18;

    // Packed stream widths.
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 136;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_REINIT = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_BAD_ALIGN   = 3'd2,
        ST_NO_MEM      = 3'd3,
        ST_BAD_INDEX   = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_DOUBLE_FREE = 3'd6
    } t_status;

endpackage
`default_nettype wire

[src/fbth_pool_ram.sv]
// Word-wide pool memory of the heap: one write port and one registered read port.
// Imports fbth_pkg; has no other dependencies.
`default_nettype none
module fbth_pool_ram
    import fbth_pkg::*;
#(
    parameter int unsigned AW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [2**AW];
    logic [15:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[src/first_fit_boundary_tag_heap.sv]
// First-fit boundary-tag heap allocator over a byte pool held in a word RAM.
// An allocation walks the block chain for a fit, a free or query for the block holding the index;
// then header fields are written (a query reads the owner instead), a free runs a merge pass over
// the chain, and every request ends with a statistics pass over the whole chain before its result.
// Throughput: one transaction at a time, set by the chain walk through the single read port.
// Reset: synchronous, active low; the pool header is written first, and nothing is ready until then.
`default_nettype none
module first_fit_boundary_tag_heap
    import fbth_pkg::*;
#(
    parameter int unsigned POOL_BYTES     = DEF_POOL_BYTES,
    parameter int unsigned ALIGN_UNIT     = DEF_ALIGN_UNIT,
    parameter int unsigned MIN_DATA_BYTES = DEF_MIN_DATA_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write: no_owner_id.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [15:0]           i_cfg_data,
    // Request stream.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata from bit 0: req_size[16], alignment[16], node_id[16], block_index[16]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode[2]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // Result stream.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata from bit 0: status[3], result_index[12], owner_id[16], used_bytes[13],
    // peak_used[13], max_free[12], block_count[11], allocated_count[11],
    // free_count[11], alloc_total[16], free_total[16], zero fill[2]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int unsigned AW = $clog2(POOL_BYTES / 2);
    localparam int unsigned BW = $clog2(POOL_BYTES + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_RD_SIZE  = 10'b00_0000_0010,
        S_RD_FLAG  = 10'b00_0000_0100,
        S_RD_PAD   = 10'b00_0000_1000,
        S_EVAL     = 10'b00_0001_0000,
        S_WRITE    = 10'b00_0010_0000,
        S_RD_OWNER = 10'b00_0100_0000,
        S_OWNER    = 10'b00_1000_0000,
        S_DONE     = 10'b01_0000_0000,
        S_SPARE    = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {PH_ALLOC, PH_FIND, PH_MERGE, PH_STATS} t_phase;
    typedef enum logic [1:0] {WK_ALLOC, WK_FREE, WK_MERGE, WK_INIT} t_wkind;

    t_state        r_state;
    t_phase        r_phase;
    t_wkind        r_wkind;
    logic [2:0]    r_wstep;
    logic          r_boot;
    t_opcode       r_op;
    logic [15:0]   r_align;
    logic [15:0]   r_node;
    logic [15:0]   r_idx;
    logic [15:0]   r_no_owner;
    logic [XW-1:0] r_b;
    logic [15:0]   r_bsize;
    logic          r_bflag;
    logic [XW-1:0] r_prev;
    logic [15:0]   r_prev_size;
    logic          r_prev_free;
    logic [XW-1:0] r_need;
    logic [XW-1:0] r_need_data;
    logic [15:0]   r_pad;
    logic [XW-1:0] r_nb;
    logic [15:0]   r_rest;
    t_status       r_status;
    logic [11:0]   r_res_idx;
    logic [15:0]   r_owner;
    logic [XW-1:0] r_used;
    logic [15:0]   r_largest;
    logic [BW-1:0] r_nblk;
    logic [BW-1:0] r_nalloc;
    logic [BW-1:0] r_nfree;
    logic [BW-1:0] r_peak;
    logic [15:0]   r_atot;
    logic [15:0]   r_ftot;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic [XW-1:0] w_base;
    logic [XW-1:0] w_off;
    logic          w_last;
    logic [XW-1:0] rd_off;

    logic [XW-1:0] next_b;
    logic          blk_ok;
    logic [XW-1:0] data_start;
    logic [XW-1:0] aligned;
    logic [XW-1:0] pad_v;
    logic [XW-1:0] need_v;
    logic [XW-1:0] rest_v;
    logic [XW-1:0] lo_v;
    logic [XW-1:0] hi_v;
    logic [15:0]   merged;
    logic [XW-1:0] in_round;
    logic [XW-1:0] in_need;
    logic [15:0]   in_size;
    logic [15:0]   in_align;
    logic [BW-1:0] peak_new;
    logic          s_acc;
    logic          m_free;

    fbth_pool_ram #(.AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Block walk arithmetic, shared by all passes.
    assign next_b     = r_b + XW'(OVH_BYTES) + XW'(r_bsize);
    assign blk_ok     = (r_b + XW'(OVH_BYTES)) <= XW'(POOL_BYTES);
    assign data_start = r_b + XW'(HDR_BYTES);
    assign aligned    = (data_start + XW'(r_align) - XW'(1)) & ~(XW'(r_align) - XW'(1));
    assign pad_v      = aligned - data_start;
    assign need_v     = pad_v + r_need_data;
    assign rest_v     = XW'(r_bsize) - need_v;
    assign lo_v       = data_start + XW'(ram_rdata);
    assign hi_v       = data_start + XW'(r_bsize);
    assign merged     = r_prev_size + 16'(OVH_BYTES) + r_bsize;

    // Request decode of the incoming size and alignment.
    assign in_size  = i_s_axis_tdata[15:0];
    assign in_align = i_s_axis_tdata[31:16];
    assign in_round = XW'(((XW'(in_size) + XW'(ALIGN_UNIT - 1)) / XW'(ALIGN_UNIT))
                          * XW'(ALIGN_UNIT));
    assign in_need  = (in_round < XW'(MIN_DATA_BYTES)) ? XW'(MIN_DATA_BYTES) : in_round;

    assign peak_new = (r_used > XW'(r_peak)) ? BW'(r_used) : r_peak;

    assign s_acc  = i_s_axis_tvalid && (r_state == S_IDLE);
    assign m_free = !r_m_valid || i_m_axis_tready;

    // Header write list for each kind of update.
    always_comb begin
        w_base    = r_b;
        w_off     = XW'(OFF_SIZE);
        ram_wdata = '0;
        w_last    = 1'b0;
        case (r_wkind)
            WK_ALLOC: begin
                case (r_wstep)
                    3'd0: begin
                        w_base = r_nb; w_off = XW'(OFF_SIZE);
                        ram_wdata = r_rest - 16'(OVH_BYTES);
                    end
                    3'd1: begin w_base = r_nb; w_off = XW'(OFF_FLAGS); end
                    3'd2: begin w_base = r_nb; w_off = XW'(OFF_OWNER); ram_wdata = r_no_owner; end
                    3'd3: begin w_base = r_nb; w_off = XW'(OFF_PAD); end
                    3'd4: begin w_off = XW'(OFF_SIZE); ram_wdata = 16'(r_need); end
                    3'd5: begin w_off = XW'(OFF_PAD); ram_wdata = r_pad; end
                    3'd6: begin w_off = XW'(OFF_FLAGS); ram_wdata = 16'd1; end
                    default: begin w_off = XW'(OFF_OWNER); ram_wdata = r_node; w_last = 1'b1; end
                endcase
            end
            WK_FREE: begin
                case (r_wstep)
                    3'd0: w_off = XW'(OFF_FLAGS);
                    3'd1: begin w_off = XW'(OFF_OWNER); ram_wdata = r_no_owner; end
                    default: begin w_off = XW'(OFF_PAD); w_last = 1'b1; end
                endcase
            end
            WK_MERGE: begin
                w_base = r_prev;
                case (r_wstep)
                    3'd0: begin w_off = XW'(OFF_SIZE); ram_wdata = r_prev_size; end
                    default: begin w_off = XW'(OFF_PAD); w_last = 1'b1; end
                endcase
            end
            default: begin
                w_base = '0;
                case (r_wstep)
                    3'd0: begin
                        w_off = XW'(OFF_SIZE);
                        ram_wdata = 16'(POOL_BYTES - OVH_BYTES);
                    end
                    3'd1: w_off = XW'(OFF_FLAGS);
                    3'd2: begin w_off = XW'(OFF_OWNER); ram_wdata = r_no_owner; end
                    default: begin w_off = XW'(OFF_PAD); w_last = 1'b1; end
                endcase
            end
        endcase
    end

    // RAM port selection.
    always_comb begin
        unique case (r_state)
            S_RD_FLAG:  rd_off = r_b + XW'(OFF_FLAGS);
            S_RD_PAD:   rd_off = r_b + XW'(OFF_PAD);
            S_RD_OWNER: rd_off = r_b + XW'(OFF_OWNER);
            default:    rd_off = r_b + XW'(OFF_SIZE);
        endcase
    end

    assign ram_raddr = rd_off[AW:1];
    assign ram_we    = (r_state == S_WRITE);
    assign ram_waddr = AW'((w_base + w_off) >> 1);

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WRITE;
            r_wkind     <= WK_INIT;
            r_wstep     <= '0;
            r_boot      <= 1'b1;
            r_phase     <= PH_STATS;
            r_no_owner  <= 16'hFFFF;
            r_peak      <= '0;
            r_atot      <= '0;
            r_ftot      <= '0;
            r_m_valid   <= 1'b0;
            r_prev_free <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid && !r_boot) begin
                r_no_owner <= i_cfg_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op        <= t_opcode'(i_s_axis_tuser);
                        r_align     <= in_align;
                        r_node      <= i_s_axis_tdata[47:32];
                        r_idx       <= i_s_axis_tdata[63:48];
                        r_need_data <= in_need;
                        r_status    <= ST_OK;
                        r_res_idx   <= '0;
                        r_owner     <= r_no_owner;
                        r_b         <= '0;
                        r_used      <= '0;
                        r_largest   <= '0;
                        r_nblk      <= '0;
                        r_nalloc    <= '0;
                        r_nfree     <= '0;
                        r_state     <= S_RD_SIZE;
                        case (t_opcode'(i_s_axis_tuser))
                            OP_ALLOC: begin
                                r_phase <= PH_ALLOC;
                                if (in_size == 16'd0) begin
                                    r_status <= ST_ZERO_SIZE;
                                    r_phase  <= PH_STATS;
                                end else if (in_align == 16'd0 ||
                                             (in_align & (in_align - 16'd1)) != 16'd0) begin
                                    r_status <= ST_BAD_ALIGN;
                                    r_phase  <= PH_STATS;
                                end
                            end
                            OP_FREE, OP_QUERY: begin
                                r_phase <= PH_FIND;
                                if (32'(i_s_axis_tdata[63:48]) >= 32'(POOL_BYTES)) begin
                                    r_status <= ST_BAD_INDEX;
                                    r_phase  <= PH_STATS;
                                end
                            end
                            default: begin
                                r_peak  <= '0;
                                r_atot  <= '0;
                                r_ftot  <= '0;
                                r_wkind <= WK_INIT;
                                r_wstep <= '0;
                                r_state <= S_WRITE;
                            end
                        endcase
                    end
                end

                S_RD_SIZE: begin
                    if (blk_ok) begin
                        r_state <= S_RD_FLAG;
                    end else begin
                        // End of the chain closes the current pass.
                        r_b     <= '0;
                        r_phase <= PH_STATS;
                        case (r_phase)
                            PH_ALLOC: r_status <= ST_NO_MEM;
                            PH_FIND:  r_status <= ST_NOT_FOUND;
                            PH_STATS: r_state  <= S_DONE;
                            default:  r_status <= r_status;
                        endcase
                    end
                end

                S_RD_FLAG: begin
                    r_bsize <= ram_rdata;
                    r_state <= S_RD_PAD;
                end

                S_RD_PAD: begin
                    r_bflag <= ram_rdata[0];
                    r_state <= S_EVAL;
                end

                S_EVAL: begin
                    r_b     <= next_b;
                    r_state <= S_RD_SIZE;
                    case (r_phase)
                        PH_ALLOC: begin
                            if (!r_bflag && XW'(r_bsize) >= need_v) begin
                                r_b       <= r_b;
                                r_pad     <= 16'(pad_v);
                                r_need    <= need_v;
                                r_rest    <= 16'(rest_v);
                                r_nb      <= r_b + XW'(OVH_BYTES) + need_v;
                                r_res_idx <= aligned[11:0];
                                r_atot    <= r_atot + 16'd1;
                                r_wkind   <= WK_ALLOC;
                                r_wstep   <= (rest_v >= XW'(OVH_BYTES + MIN_DATA_BYTES))
                                             ? 3'd0 : 3'd5;
                                r_state   <= S_WRITE;
                            end
                        end
                        PH_FIND: begin
                            if (XW'(r_idx) >= lo_v && XW'(r_idx) < hi_v) begin
                                r_b <= r_b;
                                if (r_op == OP_QUERY) begin
                                    r_state <= S_RD_OWNER;
                                end else if (!r_bflag) begin
                                    r_status <= ST_DOUBLE_FREE;
                                    r_phase  <= PH_STATS;
                                    r_b      <= '0;
                                end else begin
                                    r_ftot  <= r_ftot + 16'd1;
                                    r_wkind <= WK_FREE;
                                    r_wstep <= '0;
                                    r_state <= S_WRITE;
                                end
                            end
                        end
                        PH_MERGE: begin
                            if (r_prev_free && !r_bflag) begin
                                r_prev_size <= merged;
                                r_wkind     <= WK_MERGE;
                                r_wstep     <= '0;
                                r_state     <= S_WRITE;
                            end else begin
                                r_prev      <= r_b;
                                r_prev_size <= r_bsize;
                                r_prev_free <= !r_bflag;
                            end
                        end
                        default: begin
                            r_nblk <= r_nblk + BW'(1);
                            if (r_bflag) begin
                                r_nalloc <= r_nalloc + BW'(1);
                                r_used   <= r_used + XW'(OVH_BYTES) + XW'(r_bsize);
                            end else begin
                                r_nfree <= r_nfree + BW'(1);
                                if (r_bsize > r_largest) begin
                                    r_largest <= r_bsize;
                                end
                            end
                        end
                    endcase
                end

                S_WRITE: begin
                    r_wstep <= r_wstep + 3'd1;
                    if (w_last) begin
                        r_state <= S_RD_SIZE;
                        r_b     <= '0;
                        case (r_wkind)
                            WK_FREE: begin
                                r_phase     <= PH_MERGE;
                                r_prev_free <= 1'b0;
                            end
                            WK_MERGE: r_b <= r_prev + XW'(OVH_BYTES) + XW'(r_prev_size);
                            WK_INIT: begin
                                r_phase <= PH_STATS;
                                r_boot  <= 1'b0;
                                if (r_boot) begin
                                    r_state <= S_IDLE;
                                end
                            end
                            default:  r_phase <= PH_STATS;
                        endcase
                    end
                end

                S_RD_OWNER: begin
                    r_state <= S_OWNER;
                end

                S_OWNER: begin
                    r_owner <= ram_rdata;
                    r_phase <= PH_STATS;
                    r_b     <= '0;
                    r_state <= S_RD_SIZE;
                end

                S_DONE: begin
                    if (m_free) begin
                        r_peak    <= peak_new;
                        r_m_valid <= 1'b1;
                        r_m_data  <= {2'b00, r_ftot, r_atot, 11'(r_nfree), 11'(r_nalloc),
                                      11'(r_nblk), 12'(r_largest), 13'(peak_new), 13'(r_used),
                                      r_owner, r_res_idx, r_status};
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready     = !r_boot;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

[tb/sv/first_fit_boundary_tag_heap_tb.sv]
// Self-checking testbench for the first-fit boundary-tag heap allocator.
// Depends on fbth_pkg and first_fit_boundary_tag_heap; keeps a byte-level copy of the pool.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_boundary_tag_heap_tb;
    import fbth_pkg::*;

    localparam int unsigned POOL       = DEF_POOL_BYTES;
    localparam int unsigned UNIT       = DEF_ALIGN_UNIT;
    localparam int unsigned MIN_DATA   = DEF_MIN_DATA_BYTES;
    localparam int unsigned TAG_FREE   = 16'hF2EE;
    localparam int unsigned TAG_USED   = 16'hA10C;
    localparam int unsigned TAG_FOOT   = 16'hF007;
    localparam int unsigned FLAG_USED  = 16'h0001;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned RANDOM_ITEMS = 1330;

    // One result transaction; the first member sits in the highest bits.
    typedef struct packed {
        logic [15:0] free_total;
        logic [15:0] alloc_total;
        logic [10:0] free_count;
        logic [10:0] allocated_count;
        logic [10:0] block_count;
        logic [11:0] max_free;
        logic [12:0] peak_used;
        logic [12:0] used_bytes;
        logic [15:0] owner_id;
        logic [11:0] result_index;
        logic [2:0]  status;
    } heap_result_t;

    // A row of the directed stimulus table.
    typedef struct {
        t_opcode     op;
        logic [15:0] size;
        logic [15:0] align;
        logic [15:0] node;
        logic [15:0] index;
        bit          typed;
        t_status     status;
        logic [11:0] result_index;
    } request_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] i_s_axis_tdata = '0;
    logic [IN_USER_W-1:0] i_s_axis_tuser = '0;
    logic i_m_axis_tready = 1'b0;
    logic o_cfg_ready, o_s_axis_tready, o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    first_fit_boundary_tag_heap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the heap and its counters.
    logic [7:0]   heap_bytes [0:POOL-1];
    logic [15:0]  shadow_no_owner;
    logic [15:0]  shadow_peak, shadow_allocs, shadow_frees;
    heap_result_t expected_results [$];
    int unsigned  live_data [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    bit           quiet = 1'b0;

    function automatic int unsigned mem_rd16(int unsigned off);
        int unsigned lo, hi;
        lo = (off < POOL) ? heap_bytes[off] : 0;
        hi = (off + 1 < POOL) ? heap_bytes[off + 1] : 0;
        return lo | (hi << 8);
    endfunction

    function automatic void mem_wr16(int unsigned off, int unsigned v);
        if (off < POOL) heap_bytes[off] = v[7:0];
        if (off + 1 < POOL) heap_bytes[off + 1] = v[15:8];
    endfunction

    function automatic bit fits(int unsigned b);
        return b + OVH_BYTES <= POOL;
    endfunction

    function automatic int unsigned next_block(int unsigned b);
        return b + OVH_BYTES + mem_rd16(b + OFF_SIZE);
    endfunction

    function automatic bit in_use(int unsigned b);
        return (mem_rd16(b + OFF_FLAGS) & FLAG_USED) != 0;
    endfunction

    function automatic void write_footer(int unsigned b);
        mem_wr16(b + HDR_BYTES + mem_rd16(b + OFF_SIZE), TAG_FOOT);
    endfunction

    function automatic void carve_free(int unsigned b, int unsigned size);
        mem_wr16(b, TAG_FREE);
        mem_wr16(b + OFF_SIZE, size);
        mem_wr16(b + OFF_FLAGS, 0);
        mem_wr16(b + OFF_OWNER, shadow_no_owner);
        mem_wr16(b + OFF_PAD, 0);
        write_footer(b);
    endfunction

    function automatic void rebuild_heap();
        foreach (heap_bytes[i]) heap_bytes[i] = 8'h00;
        carve_free(0, POOL - OVH_BYTES);
        shadow_peak = '0;
        shadow_allocs = '0;
        shadow_frees = '0;
    endfunction

    // First-fit search with alignment padding and optional split.
    function automatic int unsigned place_block(int unsigned size, int unsigned align,
                                                int unsigned owner, output t_status st);
        int unsigned want, b, data, aligned, need, have, rest;
        b = 0;
        if (size == 0) begin
            st = ST_ZERO_SIZE;
            return 0;
        end
        if (align == 0 || (align & (align - 1)) != 0) begin
            st = ST_BAD_ALIGN;
            return 0;
        end
        want = ((size + UNIT - 1) / UNIT) * UNIT;
        if (want < MIN_DATA) want = MIN_DATA;
        while (fits(b)) begin
            if (!in_use(b)) begin
                data = b + HDR_BYTES;
                aligned = (data + align - 1) & ~(align - 1);
                need = (aligned - data) + want;
                have = mem_rd16(b + OFF_SIZE);
                if (have >= need) begin
                    rest = have - need;
                    if (rest >= OVH_BYTES + MIN_DATA) begin
                        carve_free(b + HDR_BYTES + need + FTR_BYTES, rest - OVH_BYTES);
                        mem_wr16(b + OFF_SIZE, need);
                    end
                    mem_wr16(b + OFF_PAD, aligned - data);
                    mem_wr16(b + OFF_FLAGS, mem_rd16(b + OFF_FLAGS) | FLAG_USED);
                    mem_wr16(b, TAG_USED);
                    mem_wr16(b + OFF_OWNER, owner);
                    write_footer(b);
                    shadow_allocs++;
                    st = ST_OK;
                    return aligned;
                end
            end
            b = next_block(b);
        end
        st = ST_NO_MEM;
        return 0;
    endfunction

    // Computes the result of one request and advances the shadow heap.
    function automatic heap_result_t predict_heap(t_opcode op, int unsigned size,
                                                  int unsigned align, int unsigned node,
                                                  int unsigned index);
        heap_result_t r;
        t_status st;
        int unsigned b, n, lo, hi, sz, used, largest, nblk, nused, nfree, found, owner;
        st = ST_OK;
        owner = shadow_no_owner;
        r = '0;
        used = 0; largest = 0; nblk = 0; nused = 0; nfree = 0;
        case (op)
            OP_ALLOC: r.result_index = 12'(place_block(size, align, node, st));
            OP_FREE, OP_QUERY: begin
                if (index >= POOL) begin
                    st = ST_BAD_INDEX;
                end else begin
                    found = POOL;
                    b = 0;
                    while (fits(b) && found == POOL) begin
                        lo = b + HDR_BYTES + mem_rd16(b + OFF_PAD);
                        hi = b + HDR_BYTES + mem_rd16(b + OFF_SIZE);
                        if (index >= lo && index < hi) found = b;
                        b = next_block(b);
                    end
                    if (found == POOL) begin
                        st = ST_NOT_FOUND;
                    end else if (op == OP_QUERY) begin
                        owner = mem_rd16(found + OFF_OWNER);
                    end else if (!in_use(found)) begin
                        st = ST_DOUBLE_FREE;
                    end else begin
                        mem_wr16(found + OFF_FLAGS, mem_rd16(found + OFF_FLAGS) & ~FLAG_USED);
                        mem_wr16(found, TAG_FREE);
                        mem_wr16(found + OFF_OWNER, shadow_no_owner);
                        mem_wr16(found + OFF_PAD, 0);
                        write_footer(found);
                        shadow_frees++;
                        // Coalesce every run of neighboring free blocks.
                        b = 0;
                        while (fits(b)) begin
                            n = next_block(b);
                            if (!in_use(b) && fits(n) && !in_use(n)) begin
                                mem_wr16(b + OFF_SIZE, mem_rd16(b + OFF_SIZE) + OVH_BYTES
                                         + mem_rd16(n + OFF_SIZE));
                                mem_wr16(b + OFF_PAD, 0);
                                write_footer(b);
                            end else begin
                                b = n;
                            end
                        end
                    end
                end
            end
            default: rebuild_heap();
        endcase
        // Statistics over the whole chain.
        b = 0;
        while (fits(b)) begin
            sz = mem_rd16(b + OFF_SIZE);
            nblk++;
            if (in_use(b)) begin
                nused++;
                used += OVH_BYTES + sz;
            end else begin
                nfree++;
                if (sz > largest) largest = sz;
            end
            b = next_block(b);
        end
        if (used > shadow_peak) shadow_peak = used[15:0];
        r.status = st;
        r.owner_id = owner[15:0];
        r.used_bytes = used[12:0];
        r.peak_used = shadow_peak[12:0];
        r.max_free = largest[11:0];
        r.block_count = nblk[10:0];
        r.allocated_count = nused[10:0];
        r.free_count = nfree[10:0];
        r.alloc_total = shadow_allocs;
        r.free_total = shadow_frees;
        return r;
    endfunction

    // Sends one request, records its expected result and tracks live allocations.
    task automatic issue_request(input request_row_t row);
        heap_result_t r;
        int k;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= row.op;
        i_s_axis_tdata <= {row.index, row.node, row.align, row.size};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        r = predict_heap(row.op, row.size, row.align, row.node, row.index);
        if (row.op == OP_ALLOC && r.status == ST_OK) live_data.push_back(r.result_index);
        if (row.op == OP_REINIT) live_data.delete();
        if (row.op == OP_FREE && r.status == ST_OK) begin
            for (k = live_data.size() - 1; k >= 0; k--)
                if (live_data[k] <= row.index && row.index < live_data[k] + MIN_DATA)
                    live_data.delete(k);
        end
        if (row.typed) begin
            r.status = row.status;
            r.result_index = row.result_index;
        end
        expected_results.push_back(r);
        if (!quiet && $urandom_range(99) < 26) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Waits until the block is idle, then writes no_owner_id.
    task automatic write_no_owner(input logic [15:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_no_owner = value;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0d actual %0d", name, want, got);
        end
    endtask

    // Result side: random back-pressure and field-by-field checking.
    always @(posedge i_clk) begin
        heap_result_t got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[$bits(heap_result_t)-1:0];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result transaction");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("result_index", want.result_index, got.result_index);
                    compare_field("owner_id", want.owner_id, got.owner_id);
                    compare_field("used_bytes", want.used_bytes, got.used_bytes);
                    compare_field("peak_used", want.peak_used, got.peak_used);
                    compare_field("max_free", want.max_free, got.max_free);
                    compare_field("block_count", want.block_count, got.block_count);
                    compare_field("allocated_count", want.allocated_count,
                                  got.allocated_count);
                    compare_field("free_count", want.free_count, got.free_count);
                    compare_field("alloc_total", want.alloc_total, got.alloc_total);
                    compare_field("free_total", want.free_total, got.free_total);
                end
            end
            i_m_axis_tready <= quiet || ($urandom_range(99) >= 26);
        end
    end

    // Builds one random request, mostly well-formed against the live allocations.
    function automatic request_row_t random_request();
        request_row_t row;
        int unsigned pick;
        row.typed = 1'b0;
        row.status = ST_OK;
        row.result_index = '0;
        row.node = 16'($urandom_range(16'hFFFF));
        row.size = 16'($urandom_range(1, 96));
        row.align = 16'd1 << $urandom_range(0, 6);
        row.index = 16'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 1) begin
            row.op = OP_REINIT;
        end else if (pick < 45) begin
            row.op = OP_ALLOC;
            if ($urandom_range(19) == 0) row.size = 16'($urandom_range(16'hFFFF));
            else if ($urandom_range(19) == 0) row.size = 16'($urandom_range(97, 1200));
            if ($urandom_range(19) == 0) row.align = 16'($urandom_range(16'hFFFF));
            else if ($urandom_range(29) == 0) row.align = 16'd1 << $urandom_range(7, 15);
        end else begin
            row.op = (pick < 80) ? OP_FREE : OP_QUERY;
            if (live_data.size() != 0 && $urandom_range(9) < 8)
                row.index = 16'(live_data[$urandom_range(live_data.size() - 1)]
                                + $urandom_range(MIN_DATA - 1));
            else if ($urandom_range(1) == 0)
                row.index = 16'($urandom_range(POOL - 1));
        end
        return row;
    endfunction

    // Directed table; status and index typed in where they are obvious.
    request_row_t directed [] = '{
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd0, 1, ST_NOT_FOUND, 12'd0},
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd4096, 1, ST_BAD_INDEX, 12'd0},
        '{OP_FREE, 16'd0, 16'd1, 16'd0, 16'hFFFF, 1, ST_BAD_INDEX, 12'd0},
        '{OP_FREE, 16'd0, 16'd1, 16'd0, 16'd10, 1, ST_DOUBLE_FREE, 12'd0},
        '{OP_ALLOC, 16'd0, 16'd1, 16'd0, 16'd0, 1, ST_ZERO_SIZE, 12'd0},
        '{OP_ALLOC, 16'd5, 16'd0, 16'd0, 16'd0, 1, ST_BAD_ALIGN, 12'd0},
        '{OP_ALLOC, 16'd5, 16'd3, 16'd0, 16'd0, 1, ST_BAD_ALIGN, 12'd0},
        '{OP_ALLOC, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1, ST_ZERO_SIZE, 12'd0},
        '{OP_ALLOC, 16'hFFFF, 16'd1, 16'd0, 16'd0, 1, ST_NO_MEM, 12'd0},
        '{OP_ALLOC, 16'd1, 16'h8000, 16'd0, 16'd0, 1, ST_NO_MEM, 12'd0},
        '{OP_ALLOC, 16'd1, 16'd1, 16'hFFFF, 16'd0, 1, ST_OK, 12'd10},
        '{OP_ALLOC, 16'd4, 16'd16, 16'd0, 16'd0, 0, ST_OK, 12'd0},
        '{OP_ALLOC, 16'd100, 16'd64, 16'h1234, 16'd0, 0, ST_OK, 12'd0},
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd10, 0, ST_OK, 12'd0},
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd30, 0, ST_OK, 12'd0},
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd130, 0, ST_OK, 12'd0},
        '{OP_FREE, 16'd0, 16'd1, 16'd0, 16'd10, 1, ST_OK, 12'd0},
        '{OP_FREE, 16'd0, 16'd1, 16'd0, 16'd10, 1, ST_DOUBLE_FREE, 12'd0},
        '{OP_QUERY, 16'd0, 16'd1, 16'd0, 16'd12, 0, ST_OK, 12'd0},
        '{OP_REINIT, 16'd0, 16'd1, 16'd0, 16'd0, 1, ST_OK, 12'd0},
        '{OP_ALLOC, 16'd4084, 16'd1, 16'h00FF, 16'd0, 1, ST_OK, 12'd10},
        '{OP_ALLOC, 16'd1, 16'd1, 16'd0, 16'd0, 1, ST_NO_MEM, 12'd0},
        '{OP_FREE, 16'd0, 16'd1, 16'd0, 16'd4093, 1, ST_OK, 12'd0},
        '{OP_REINIT, 16'd0, 16'd1, 16'd0, 16'd0, 1, ST_OK, 12'd0},
        '{OP_ALLOC, 16'd4085, 16'd1, 16'd0, 16'd0, 1, ST_NO_MEM, 12'd0}
    };

    // Stimulus: reset, directed table, then random phases with new register values.
    initial begin
        logic [15:0] owner_settings [0:4];
        int phase, n;
        owner_settings = '{16'h0000, 16'hFFFF, 16'h8001, 16'h0000, 16'h5A5A};
        owner_settings[2] = 16'($urandom_range(16'hFFFF));
        shadow_no_owner = 16'hFFFF;
        rebuild_heap();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) issue_request(directed[i]);
        for (phase = 0; phase < 5; phase++) begin
            write_no_owner(owner_settings[phase]);
            for (n = 0; n < RANDOM_ITEMS / 5; n++) begin
                quiet = (phase == 1 && n < 150);
                issue_request(random_request());
            end
        end
        quiet = 1'b0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
